// ----- rtl/csqrt_pkg.sv -----
// ----------------------------------------------------------------------------
// csqrt_pkg
// Shared constants for the complex square root pipeline: the default
// data width and fraction width of the signed fixed-point operands.
// ----------------------------------------------------------------------------
package csqrt_pkg;

    // Q16.16 operands by default
    localparam int CSQRT_DATA_WIDTH = 32;
    localparam int CSQRT_FRAC_BITS  = 16;

endpackage

// ----- rtl/complex_square_root.sv -----
// ----------------------------------------------------------------------------
// complex_square_root
// Principal square root of a signed fixed-point complex number, as a fully
// pipelined datapath: two squarers, two digit-per-stage square roots and a
// bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, with the real part in
//   the low DATA_WIDTH bits of s_tdata and the imaginary part above it.
//   One result beat leaves on m_tvalid/m_tready/m_tdata per input beat, in
//   order, with the real part of the root low and the imaginary part above.
//   Throughput is one beat per cycle while the pipe is not frozen by the
//   skid buffer (see below). A beat passes the input stage, the squarers,
//   the first square root (one root bit per stage), the second square root
//   (K2 stages, where K2 = (DATA_WIDTH + FRAC_BITS + 2) / 2) and the
//   divider (one quotient bit per stage) before the output register.
//   Operands are Q16.16 by default.
//   The output register is backed by a one-entry skid buffer. When the
//   receiver stalls, the beat leaving the pipeline lands in the skid
//   buffer and the pipe keeps accepting beats that cycle; once the skid
//   buffer holds a beat the whole pipe freezes and s_tready drops until
//   it drains. Nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) clears all valid bits; the data
//   registers are not reset and there is no warm-up.
// ----------------------------------------------------------------------------
module complex_square_root #(
    parameter int DATA_WIDTH = csqrt_pkg::CSQRT_DATA_WIDTH,
    parameter int FRAC_BITS  = csqrt_pkg::CSQRT_FRAC_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // in_real, in_imag, zero fill
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]          s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // root_real, root_imag, zero fill
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]          m_tdata
);

    import csqrt_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int TW  = ((2*DW+7)/8)*8;
    localparam int SW  = 2*DW;            // sum of squares
    localparam int RW1 = DW+2;            // first root remainder
    localparam int N2W = DW+1+FB;         // second radicand
    localparam int K2  = (N2W+1)/2;       // second root bits
    localparam int RW2 = K2+2;            // second root remainder
    localparam int QW  = DW+FB;           // quotient bits
    localparam int DRW = K2+2;            // divider remainder
    localparam int CW  = (K2 > DW) ? K2 : DW;

    localparam logic [DW-1:0] CAP = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        logic          rneg;
        logic          ineg;
        logic          zero;
        logic [DW-1:0] rmag;
        logic [DW-1:0] imag;
    } side_t;

    logic en;

    // ---------------------------------------------------------------- stage A
    logic          a_valid_reg;
    side_t         a_side_reg;
    logic [DW-1:0] in_real;
    logic [DW-1:0] in_imag;
    side_t         a_side_next;

    assign in_real = s_tdata[DW-1:0];
    assign in_imag = s_tdata[2*DW-1:DW];

    always_comb
    begin
        a_side_next.rneg = in_real[DW-1];
        a_side_next.ineg = in_imag[DW-1];
        a_side_next.zero = (in_real == '0) && (in_imag == '0);
        a_side_next.rmag = in_real[DW-1] ? (~in_real + 1'b1) : in_real;
        a_side_next.imag = in_imag[DW-1] ? (~in_imag + 1'b1) : in_imag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_side_reg <= a_side_next;
    end

    // ---------------------------------------------------------------- squares
    logic          b_valid_reg;
    side_t         b_side_reg;
    logic [SW-1:0] b_rr_reg;
    logic [SW-1:0] b_ii_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg <= a_side_reg;
            b_rr_reg   <= SW'(a_side_reg.rmag) * SW'(a_side_reg.rmag);
            b_ii_reg   <= SW'(a_side_reg.imag) * SW'(a_side_reg.imag);
        end
    end

    // ---------------------------------------------- magnitude root, bit/stage
    logic           q1_valid_reg [DW+1];
    side_t          q1_side_reg  [DW+1];
    logic [SW-1:0]  q1_rad_reg   [DW+1];
    logic [RW1-1:0] q1_rem_reg   [DW+1];
    logic [DW-1:0]  q1_root_reg  [DW+1];

    // sum of squares enters the root chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q1_valid_reg[0] <= 1'b0;
        else if (en)
            q1_valid_reg[0] <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_side_reg[0] <= b_side_reg;
            q1_rad_reg[0]  <= b_rr_reg + b_ii_reg;
            q1_rem_reg[0]  <= '0;
            q1_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < DW; k++)
    begin : g_root1
        logic [RW1-1:0] rem_sh;
        logic [RW1-1:0] trial;
        logic           ge;
        logic [RW1-1:0] rem_next;
        logic [DW-1:0]  root_next;

        // bring down two radicand bits, try the next root bit
        always_comb
        begin
            rem_sh    = {q1_rem_reg[k][RW1-3:0], q1_rad_reg[k][2*(DW-1-k)+1 -: 2]};
            trial     = {q1_root_reg[k], 2'b01};
            ge        = rem_sh >= trial;
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {q1_root_reg[k][DW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q1_valid_reg[k+1] <= 1'b0;
            else if (en)
                q1_valid_reg[k+1] <= q1_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q1_side_reg[k+1] <= q1_side_reg[k];
                q1_rad_reg[k+1]  <= q1_rad_reg[k];
                q1_rem_reg[k+1]  <= rem_next;
                q1_root_reg[k+1] <= root_next;
            end
        end
    end

    // ------------------------------------------------- half-sum root, bit/stage
    logic            q2_valid_reg [K2+1];
    side_t           q2_side_reg  [K2+1];
    logic [2*K2-1:0] q2_rad_reg   [K2+1];
    logic [RW2-1:0]  q2_rem_reg   [K2+1];
    logic [K2-1:0]   q2_root_reg  [K2+1];
    logic [DW:0]     t_sum;
    logic [2*K2-1:0] rad2;

    // (|re| + m) scaled by 2^FB and halved
    always_comb
    begin
        t_sum = {1'b0, q1_side_reg[DW].rmag} + {1'b0, q1_root_reg[DW]};
        rad2  = ((2*K2)'(t_sum) << FB) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q2_valid_reg[0] <= 1'b0;
        else if (en)
            q2_valid_reg[0] <= q1_valid_reg[DW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_side_reg[0] <= q1_side_reg[DW];
            q2_rad_reg[0]  <= rad2;
            q2_rem_reg[0]  <= '0;
            q2_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < K2; k++)
    begin : g_root2
        logic [RW2-1:0] rem_sh;
        logic [RW2-1:0] trial;
        logic           ge;
        logic [RW2-1:0] rem_next;
        logic [K2-1:0]  root_next;

        always_comb
        begin
            rem_sh    = {q2_rem_reg[k][RW2-3:0], q2_rad_reg[k][2*(K2-1-k)+1 -: 2]};
            trial     = {q2_root_reg[k], 2'b01};
            ge        = rem_sh >= trial;
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {q2_root_reg[k][K2-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q2_valid_reg[k+1] <= 1'b0;
            else if (en)
                q2_valid_reg[k+1] <= q2_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q2_side_reg[k+1] <= q2_side_reg[k];
                q2_rad_reg[k+1]  <= q2_rad_reg[k];
                q2_rem_reg[k+1]  <= rem_next;
                q2_root_reg[k+1] <= root_next;
            end
        end
    end

    // ------------------------------------------------ divider |im|/(2W), bit/stage
    logic           d_valid_reg [QW+1];
    side_t          d_side_reg  [QW+1];
    logic [DW-1:0]  d_wsat_reg  [QW+1];
    logic [K2:0]    d_den_reg   [QW+1];
    logic [QW-1:0]  d_num_reg   [QW+1];
    logic [DRW-1:0] d_rem_reg   [QW+1];
    logic [QW-1:0]  d_quo_reg   [QW+1];
    logic [DW-1:0]  wsat;

    // saturated W for the output side
    always_comb
    begin
        if (CW'(q2_root_reg[K2]) > CW'(CAP))
            wsat = CAP;
        else
            wsat = DW'(q2_root_reg[K2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg[0] <= 1'b0;
        else if (en)
            d_valid_reg[0] <= q2_valid_reg[K2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg[0] <= q2_side_reg[K2];
            d_wsat_reg[0] <= wsat;
            d_den_reg[0]  <= {q2_root_reg[K2], 1'b0};
            d_num_reg[0]  <= QW'(q2_side_reg[K2].imag) << FB;
            d_rem_reg[0]  <= '0;
            d_quo_reg[0]  <= '0;
        end
    end

    // a zero divisor yields an all-ones quotient, which saturates below
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DRW-1:0] rem_sh;
        logic           ge;
        logic [DRW-1:0] rem_next;
        logic [QW-1:0]  quo_next;

        always_comb
        begin
            rem_sh   = {d_rem_reg[k][DRW-2:0], d_num_reg[k][QW-1-k]};
            ge       = rem_sh >= DRW'(d_den_reg[k]);
            rem_next = ge ? (rem_sh - DRW'(d_den_reg[k])) : rem_sh;
            quo_next = {d_quo_reg[k][QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_valid_reg[k+1] <= 1'b0;
            else if (en)
                d_valid_reg[k+1] <= d_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_side_reg[k+1] <= d_side_reg[k];
                d_wsat_reg[k+1] <= d_wsat_reg[k];
                d_den_reg[k+1]  <= d_den_reg[k];
                d_num_reg[k+1]  <= d_num_reg[k];
                d_rem_reg[k+1]  <= rem_next;
                d_quo_reg[k+1]  <= quo_next;
            end
        end
    end

    // --------------------------------------------------- result assembly
    logic          p_valid;
    side_t         f_side;
    logic [DW-1:0] qsat;
    logic [DW-1:0] mag_re;
    logic [DW-1:0] mag_im;
    logic [DW-1:0] root_real;
    logic [DW-1:0] root_imag;
    logic [TW-1:0] f_data;

    assign p_valid = d_valid_reg[QW];
    assign f_side  = d_side_reg[QW];

    always_comb
    begin
        if (d_quo_reg[QW] > QW'(CAP))
            qsat = CAP;
        else
            qsat = d_quo_reg[QW][DW-1:0];

        // negative real part swaps the roles of W and the quotient
        if (f_side.rneg)
        begin
            mag_re = qsat;
            mag_im = d_wsat_reg[QW];
        end
        else
        begin
            mag_re = d_wsat_reg[QW];
            mag_im = qsat;
        end

        if (f_side.zero)
        begin
            root_real = '0;
            root_imag = '0;
        end
        else
        begin
            root_real = mag_re;
            root_imag = f_side.ineg ? (~mag_im + 1'b1) : mag_im;
        end

        f_data = TW'({root_imag, root_real});
    end

    // --------------------------------------------- output register and skid
    logic          out_valid_reg;
    logic [TW-1:0] out_data_reg;
    logic          skid_valid_reg;
    logic [TW-1:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= p_valid;
        end
        else if (p_valid && !skid_valid_reg)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else
                out_data_reg <= f_data;
        end
        else if (!skid_valid_reg)
            skid_data_reg <= f_data;
    end

    // ---------------------------------------------------------- assertions
    // skid buffer only fills behind a held output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a beat while output is empty");

    // principal branch: real part of the root is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[DW-1])
        else $error("negative real part on output");

    // a frozen pipe keeps its last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(d_valid_reg[QW]))
        else $error("pipeline moved while frozen");

endmodule
